@@ hdl/afu_pkg.sv @@
// Shared constants, types and codes of the activation function unit.
package afu_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 12;

   // Internal magnitudes carry QB fractional bits.
   localparam int QB = 30;
   localparam int SH = QB - FRAC_BITS;

   localparam logic [30:0] Q_ONE = 31'h4000_0000;
   localparam logic [29:0] Q_LN2 = 30'd744261118;
   localparam logic [29:0] Q_GC  = 30'd856722024;
   localparam logic [25:0] Q_GK  = 26'd48012366;

   localparam int GELU_LIMIT = 8;
   localparam int SILU_LIMIT = 32;

   // Exponent argument, integer part of a/ln2, series length, exp and quotient widths.
   localparam int ARG_W = 36;
   localparam int K_W   = 7;
   localparam int TERMS = 12;
   localparam int EXP_W = 31;
   localparam int QUO_W = 31;

   typedef enum logic [1:0] {
      MODE_RELU = 2'd0,
      MODE_GELU = 2'd1,
      MODE_SILU = 2'd2
   } mode_type;

   typedef struct packed {
      mode_type               mode;
      logic                   neg;
      logic [DATA_WIDTH-1:0]  mag;
   } side_type;

endpackage

@@ hdl/afu_exp_div.sv @@
// Pipelined exp(-a) series and restoring divider giving tanh or sigmoid.
module afu_exp_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  afu_pkg::side_type           in_side,
   input  logic [afu_pkg::ARG_W-1:0]   in_arg,
   output logic                        out_valid,
   output afu_pkg::side_type           out_side,
   output logic [afu_pkg::QUO_W-1:0]   out_quo
);
   import afu_pkg::*;

   localparam int TAY_STAGES = 3 * (TERMS - 1);
   localparam int SHIFT_W    = $clog2(EXP_W);
   localparam bit LAST_SUB   = (TERMS % 2) == 1;

   typedef struct packed {
      side_type              side;
      logic [ARG_W-1:0]      rem;
      logic [K_W-1:0]        k;
   } kd_type;

   typedef struct packed {
      side_type              side;
      logic [K_W-1:0]        k;
      logic [29:0]           r;
      logic [29:0]           term;
      logic [29:0]           prod;
      logic [29:0]           est;
      logic [EXP_W-1:0]      sum;
   } tay_type;

   typedef struct packed {
      side_type              side;
      logic [31:0]           den;
      logic [31:0]           rem;
      logic [QUO_W-1:0]      quo;
   } dv_type;

   kd_type              kd_ff      [K_W];
   logic                kd_vld_ff  [K_W];
   tay_type             tay_ff     [TAY_STAGES];
   logic                tay_vld_ff [TAY_STAGES];
   tay_type             tay_entry;
   tay_type             tay_last;
   side_type            ex_side_ff;
   logic [EXP_W-1:0]    ex_val_ff;
   logic                ex_vld_ff;
   logic [EXP_W-1:0]    ex_sum;
   logic [EXP_W-1:0]    ex_val_in;
   dv_type              dv0_ff;
   dv_type              dv0_in;
   logic                dv0_vld_ff;
   dv_type              dv_ff      [QUO_W];
   logic                dv_vld_ff  [QUO_W];

   // Integer part of a/ln2, one quotient bit per stage.
   for (genvar j = 0; j < K_W; j++) begin : g_kd
      localparam int BIT = K_W - 1 - j;
      localparam logic [ARG_W-1:0] STEP = ARG_W'(Q_LN2) << BIT;
      kd_type kd_src;
      kd_type kd_in;
      logic   kd_src_v;

      if (j == 0) begin : g_first
         assign kd_src   = '{side: in_side, rem: in_arg, k: '0};
         assign kd_src_v = in_valid;
      end else begin : g_rest
         assign kd_src   = kd_ff[j-1];
         assign kd_src_v = kd_vld_ff[j-1];
      end

      always_comb begin
         kd_in = kd_src;
         if (kd_src.rem >= STEP) begin
            kd_in.rem    = kd_src.rem - STEP;
            kd_in.k[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            kd_vld_ff[j] <= 1'b0;
         end else if (advance) begin
            kd_vld_ff[j] <= kd_src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            kd_ff[j] <= kd_in;
         end
      end
   end

   // After the reduction the remainder r is below ln2; the first series term is r itself.
   always_comb begin
      tay_entry      = '0;
      tay_entry.side = kd_ff[K_W-1].side;
      tay_entry.k    = kd_ff[K_W-1].k;
      tay_entry.r    = 30'(kd_ff[K_W-1].rem);
      tay_entry.term = 30'(kd_ff[K_W-1].rem);
      tay_entry.sum  = Q_ONE;
   end

   // Each further term takes three stages: product with r, reciprocal estimate of the
   // division by n, and a one-step correction of that estimate.
   for (genvar g = 0; g < TERMS - 1; g++) begin : g_term
      localparam int N = g + 2;
      localparam bit PREV_SUB = ((N - 1) % 2) == 1;
      localparam logic [31:0] RECIP = 32'((64'd1 << 32) / N);
      localparam logic [29:0] NV = 30'(N);
      tay_type     a_src;
      logic        a_src_v;
      tay_type     a_in;
      tay_type     b_in;
      tay_type     c_in;
      logic [59:0] a_prod;
      logic [61:0] b_prod;
      logic [29:0] c_rem;

      if (g == 0) begin : g_first
         assign a_src   = tay_entry;
         assign a_src_v = kd_vld_ff[K_W-1];
      end else begin : g_rest
         assign a_src   = tay_ff[3*g-1];
         assign a_src_v = tay_vld_ff[3*g-1];
      end

      assign a_prod = 60'(a_src.term) * 60'(a_src.r);
      assign b_prod = 62'(tay_ff[3*g].prod) * 62'(RECIP);
      assign c_rem  = tay_ff[3*g+1].prod - (tay_ff[3*g+1].est * NV);

      always_comb begin
         a_in      = a_src;
         a_in.prod = 30'(a_prod >> QB);
         if (PREV_SUB) begin
            a_in.sum = a_src.sum - EXP_W'(a_src.term);
         end else begin
            a_in.sum = a_src.sum + EXP_W'(a_src.term);
         end
      end

      always_comb begin
         b_in     = tay_ff[3*g];
         b_in.est = 30'(b_prod >> 32);
      end

      always_comb begin
         c_in      = tay_ff[3*g+1];
         c_in.term = tay_ff[3*g+1].est + 30'(c_rem >= NV);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tay_vld_ff[3*g]   <= 1'b0;
            tay_vld_ff[3*g+1] <= 1'b0;
            tay_vld_ff[3*g+2] <= 1'b0;
         end else if (advance) begin
            tay_vld_ff[3*g]   <= a_src_v;
            tay_vld_ff[3*g+1] <= tay_vld_ff[3*g];
            tay_vld_ff[3*g+2] <= tay_vld_ff[3*g+1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            tay_ff[3*g]   <= a_in;
            tay_ff[3*g+1] <= b_in;
            tay_ff[3*g+2] <= c_in;
         end
      end
   end

   // Last term folds into the sum, then the result is scaled by 2^-k.
   assign tay_last = tay_ff[TAY_STAGES-1];

   always_comb begin
      if (LAST_SUB) begin
         ex_sum = tay_last.sum - EXP_W'(tay_last.term);
      end else begin
         ex_sum = tay_last.sum + EXP_W'(tay_last.term);
      end
      if (tay_last.k >= K_W'(QB + 1)) begin
         ex_val_in = '0;
      end else begin
         ex_val_in = ex_sum >> tay_last.k[SHIFT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_vld_ff <= 1'b0;
      end else if (advance) begin
         ex_vld_ff <= tay_vld_ff[TAY_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ex_side_ff <= tay_last.side;
         ex_val_ff  <= ex_val_in;
      end
   end

   // tanh divides (1-e) by (1+e), sigmoid divides 1 by (1+e); the numerator never
   // exceeds the denominator, so the quotient fits in QB+1 bits.
   always_comb begin
      dv0_in      = '0;
      dv0_in.side = ex_side_ff;
      dv0_in.den  = 32'(Q_ONE) + 32'(ex_val_ff);
      if (ex_side_ff.mode == MODE_GELU) begin
         dv0_in.rem = 32'(Q_ONE) - 32'(ex_val_ff);
      end else begin
         dv0_in.rem = 32'(Q_ONE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv0_vld_ff <= 1'b0;
      end else if (advance) begin
         dv0_vld_ff <= ex_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dv0_ff <= dv0_in;
      end
   end

   for (genvar g = 0; g < QUO_W; g++) begin : g_div
      dv_type      dv_src;
      dv_type      dv_in;
      logic        dv_src_v;
      logic [31:0] dv_remx;

      if (g == 0) begin : g_first
         assign dv_src   = dv0_ff;
         assign dv_src_v = dv0_vld_ff;
         assign dv_remx  = dv0_ff.rem;
      end else begin : g_rest
         assign dv_src   = dv_ff[g-1];
         assign dv_src_v = dv_vld_ff[g-1];
         assign dv_remx  = dv_ff[g-1].rem << 1;
      end

      always_comb begin
         dv_in = dv_src;
         if (dv_remx >= dv_src.den) begin
            dv_in.rem = dv_remx - dv_src.den;
            dv_in.quo = {dv_src.quo[QUO_W-2:0], 1'b1};
         end else begin
            dv_in.rem = dv_remx;
            dv_in.quo = {dv_src.quo[QUO_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[g] <= 1'b0;
         end else if (advance) begin
            dv_vld_ff[g] <= dv_src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            dv_ff[g] <= dv_in;
         end
      end
   end

   assign out_valid = dv_vld_ff[QUO_W-1];
   assign out_side  = dv_ff[QUO_W-1].side;
   assign out_quo   = dv_ff[QUO_W-1].quo;

endmodule

@@ hdl/activation_function_unit.sv @@
// One sample per cycle is sustained through the pipeline while rsp_stall does not hold the response.
// The depth comes from the 12-term exp series (three stages per term after the first) and the
// 31-stage restoring divider that forms tanh or sigmoid; every mode takes the same path.
// While the response is held, the pipeline freezes and one more request lands in a skid register.
// Synchronous active-high reset clears all valid bits and sets the mode to ReLU.
module activation_function_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [1:0]                           csr_wr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [afu_pkg::DATA_WIDTH-1:0] req_sample_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [afu_pkg::DATA_WIDTH-1:0] rsp_sample_out
);
   import afu_pkg::*;

   localparam int DW    = DATA_WIDTH;
   localparam int PQ_W  = 35;
   localparam int MAG_W = DW + 1;
   localparam logic [MAG_W-1:0] HALF = MAG_W'(1) << (DW - 1);
   localparam logic [PQ_W-1:0]  RND  = PQ_W'(1) << (SH - 1);

   mode_type            mode_ff;
   logic                advance;
   logic                req_xfer;
   logic                skid_valid_ff;
   logic [DW-1:0]       skid_data_ff;
   logic [DW-1:0]       in_raw;
   logic                in_valid;
   side_type            s0_in;

   side_type            s0_ff, s1_ff, s2_ff, s3_ff, s4_ff;
   logic                v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic [29:0]         kv2a_ff, kv2a_in;
   logic [31:0]         w_ff, w_in;
   logic [31:0]         cw_ff, cw_in;
   logic [ARG_W-1:0]    arg_ff, arg_in;
   logic [26+DW-1:0]    gk_prod;
   logic [30+DW-1:0]    kv_prod;
   logic [61:0]         gc_prod;
   logic [32+DW-1:0]    u_prod;

   logic                core_valid;
   side_type            core_side;
   logic [QUO_W-1:0]    core_quo;

   side_type            p1_side_ff, p2_side_ff, p3_side_ff;
   logic                p1_vld_ff, p2_vld_ff, p3_vld_ff;
   logic [31:0]         f_ff, f_in;
   logic [32+DW-1:0]    f_prod;
   logic [PQ_W-1:0]     pq_ff, pq_in;
   logic [PQ_W-1:0]     pq_rnd;
   logic [MAG_W-1:0]    mag_ff, mag_in;

   logic                big;
   logic                res_neg;
   logic [MAG_W-1:0]    res_mag;
   logic [MAG_W-1:0]    sat_mag;
   logic [DW-1:0]       rsp_sample_ff, rsp_sample_in;
   logic                rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RELU;
      end else if (csr_wr_en) begin
         mode_ff <= mode_type'(csr_wr_data);
      end
   end

   // Request side: the skid register holds one transfer taken while the pipeline is frozen.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign req_xfer  = req_valid && !skid_valid_ff;
   assign in_raw    = skid_valid_ff ? skid_data_ff : req_sample_in;
   assign in_valid  = skid_valid_ff || req_xfer;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (advance) begin
         skid_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!advance && req_xfer) begin
         skid_data_ff <= req_sample_in;
      end
   end

   always_comb begin
      s0_in.mode = mode_ff;
      s0_in.neg  = in_raw[DW-1];
      s0_in.mag  = in_raw[DW-1] ? (~in_raw + 1'b1) : in_raw;
   end

   // GELU inner argument u = C*(1 + K*v^2)*v, built one multiply per stage.
   assign gk_prod = (26+DW)'(Q_GK) * (26+DW)'(s0_ff.mag);
   assign kv2a_in = 30'(gk_prod >> FRAC_BITS);
   assign kv_prod = (30+DW)'(kv2a_ff) * (30+DW)'(s1_ff.mag);
   assign w_in    = 32'(kv_prod >> FRAC_BITS) + 32'(Q_ONE);
   assign gc_prod = 62'(Q_GC) * 62'(w_ff);
   assign cw_in   = 32'(gc_prod >> QB);
   assign u_prod  = (32+DW)'(cw_ff) * (32+DW)'(s3_ff.mag);

   // GELU needs exp(-2u) for tanh; SiLU needs exp(-|v|) for the sigmoid.
   always_comb begin
      if (s3_ff.mode == MODE_GELU) begin
         arg_in = {(ARG_W-1)'(u_prod >> FRAC_BITS), 1'b0};
      end else begin
         arg_in = ARG_W'(s3_ff.mag) << SH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_ff   <= s0_in;
         s1_ff   <= s0_ff;
         kv2a_ff <= kv2a_in;
         s2_ff   <= s1_ff;
         w_ff    <= w_in;
         s3_ff   <= s2_ff;
         cw_ff   <= cw_in;
         s4_ff   <= s3_ff;
         arg_ff  <= arg_in;
      end
   end

   afu_exp_div u_exp_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (v4_ff),
      .in_side   (s4_ff),
      .in_arg    (arg_ff),
      .out_valid (core_valid),
      .out_side  (core_side),
      .out_quo   (core_quo)
   );

   // Negative inputs use 1-t or 1-s so that every factor stays a magnitude.
   always_comb begin
      if (core_side.mode == MODE_GELU) begin
         f_in = core_side.neg ? (32'(Q_ONE) - 32'(core_quo)) : (32'(Q_ONE) + 32'(core_quo));
      end else begin
         f_in = core_side.neg ? (32'(Q_ONE) - 32'(core_quo)) : 32'(core_quo);
      end
   end

   // The extra right shift for GELU is the factor one half.
   assign f_prod = (32+DW)'(p1_side_ff.mag) * (32+DW)'(f_ff);

   always_comb begin
      if (p1_side_ff.mode == MODE_GELU) begin
         pq_in = PQ_W'(f_prod >> (FRAC_BITS + 1));
      end else begin
         pq_in = PQ_W'(f_prod >> FRAC_BITS);
      end
   end

   assign pq_rnd = pq_ff + RND;
   assign mag_in = MAG_W'(pq_rnd >> SH);

   // Final selection: pass-through cases, saturation and sign.
   always_comb begin
      big = ((p3_side_ff.mode == MODE_GELU) &&
             (32'(p3_side_ff.mag) >= (32'(GELU_LIMIT) << FRAC_BITS))) ||
            ((p3_side_ff.mode == MODE_SILU) &&
             (32'(p3_side_ff.mag) >= (32'(SILU_LIMIT) << FRAC_BITS)));
      res_neg = 1'b0;
      res_mag = '0;
      unique case (p3_side_ff.mode)
         MODE_RELU: begin
            res_mag = p3_side_ff.neg ? '0 : MAG_W'(p3_side_ff.mag);
         end
         MODE_GELU, MODE_SILU: begin
            if (big) begin
               res_mag = p3_side_ff.neg ? '0 : MAG_W'(p3_side_ff.mag);
            end else begin
               res_mag = mag_ff;
               res_neg = p3_side_ff.neg;
            end
         end
         default: begin
            res_mag = '0;
         end
      endcase
      if (res_neg) begin
         sat_mag       = (res_mag > HALF) ? HALF : res_mag;
         rsp_sample_in = ~DW'(sat_mag) + 1'b1;
      end else begin
         sat_mag       = (res_mag > (HALF - 1'b1)) ? (HALF - 1'b1) : res_mag;
         rsp_sample_in = DW'(sat_mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         p3_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_vld_ff    <= core_valid;
         p2_vld_ff    <= p1_vld_ff;
         p3_vld_ff    <= p2_vld_ff;
         rsp_valid_ff <= p3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_side_ff    <= core_side;
         f_ff          <= f_in;
         p2_side_ff    <= p1_side_ff;
         pq_ff         <= pq_in;
         p3_side_ff    <= p2_side_ff;
         mag_ff        <= mag_in;
         rsp_sample_ff <= rsp_sample_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

endmodule
